>>> hdl/spo_pkg.sv
package spo_pkg;

    localparam int PHASE_BITS     = 24;
    localparam int MAX_BLOCK_LOG2 = 6;

    localparam int FREQ_W     = 24;
    localparam int OUT_W      = 24;
    localparam int START_W    = 24;
    localparam int SCALE_W    = 32;
    localparam int KREG_W     = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam int RAMP_W = PHASE_BITS + MAX_BLOCK_LOG2;
    localparam int CNT_W  = (MAX_BLOCK_LOG2 > 0) ? MAX_BLOCK_LOG2 : 1;
    localparam int K_MAXV = (MAX_BLOCK_LOG2 > 7) ? 7 : MAX_BLOCK_LOG2;

    localparam int PROD_W    = FREQ_W + SCALE_W + 1;
    localparam int INC_SHIFT = 48 - PHASE_BITS;
    localparam int INC_W     = PROD_W - INC_SHIFT;
    localparam int STEP_W    = INC_W + K_MAXV;

    localparam logic [KREG_W-1:0] BLOCK_LOG2_RESET = KREG_W'(6);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INCREMENT_SCALE = 2'd0,
        CFG_CONTROL_MODE    = 2'd1,
        CFG_BLOCK_SIZE_LOG2 = 2'd2,
        CFG_START_PHASE     = 2'd3
    } t_cfg_index;

endpackage

>>> hdl/sawtooth_phase_oscillator_core.sv
// sawtooth phase oscillator core
//
// input channel: i_in_valid / o_in_stall carry one signed Q16.8 frequency
// sample per transfer on i_frequency. output channel: o_out_valid /
// i_out_stall carry one signed Q1.23 saw sample per transfer on o_saw_sample,
// exactly one result for every input transfer, in order.
//
// an input transfer is held in the input register; when the output register
// is free or being read, the multiply, phase update and ramp results land in
// the output register and o_out_valid rises. throughput is one sample per
// cycle: with no receiver stall both registers move on every edge.
//
// when the receiver stalls, the output register holds and the input register
// still takes one more sample; o_in_stall rises only when both are full.
// configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at the
// write edge; writing the start phase reloads the phase at once.
// reset clears the valid flags of both pipeline registers and loads the register reset values.
module sawtooth_phase_oscillator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [spo_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [spo_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [spo_pkg::FREQ_W-1:0]    i_frequency,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [spo_pkg::OUT_W-1:0]     o_saw_sample
);
    import spo_pkg::*;

    localparam int PB  = PHASE_BITS;
    localparam int RW  = RAMP_W;
    localparam int PXW = PB + OUT_W;
    localparam int RXW = RW + OUT_W;
    localparam int SXW = PB + START_W;

    localparam int OUT_SHR = (PB >= OUT_W) ? PB - OUT_W : 0;
    localparam int OUT_SHL = (PB < OUT_W) ? OUT_W - PB : 0;
    localparam int RMP_SHR = (RW >= OUT_W) ? RW - OUT_W : 0;
    localparam int RMP_SHL = (RW < OUT_W) ? OUT_W - RW : 0;
    localparam int SP_SHL  = (PB >= START_W) ? PB - START_W : 0;
    localparam int SP_SHR  = (PB < START_W) ? START_W - PB : 0;

    localparam logic signed [STEP_W-1:0] STEP_LIM = STEP_W'((64'sd1 <<< PB) - 64'sd1);
    localparam logic signed [PB+1:0] SUM_ONE = (PB+2)'(64'sd1 <<< (PB - 1));
    localparam logic signed [PB+1:0] SUM_TWO = (PB+2)'(64'sd1 <<< PB);
    localparam logic signed [RW+1:0] RAMP_HI = (RW+2)'((64'sd1 <<< (RW - 1)) - 64'sd1);
    localparam logic signed [RW+1:0] RAMP_LO = -(RW+2)'(64'sd1 <<< (RW - 1));
    localparam logic [KREG_W-1:0] K_MAX = KREG_W'(K_MAXV);

    logic [SCALE_W-1:0]       r_inc_scale;
    logic                     r_control_mode;
    logic [KREG_W-1:0]        r_block_log2;
    logic signed [PB-1:0]     r_phase, n_phase;
    logic signed [RW-1:0]     r_ramp, n_ramp;
    logic signed [RW:0]       r_slope, n_slope;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_in_valid;
    logic signed [FREQ_W-1:0] r_freq;
    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_saw, n_saw;

    logic                     adv;
    logic                     ld_start;
    logic [KREG_W-1:0]        k;
    logic signed [PROD_W-1:0] prod;
    logic signed [INC_W-1:0]  inc;
    logic signed [STEP_W-1:0] step_raw;
    logic signed [PB:0]       step_sat;
    logic signed [PB+1:0]     sum, sum_wrap;
    logic signed [RW-1:0]     target;
    logic signed [RW:0]       diff, slope_use;
    logic signed [RW+1:0]     ramp_sum;
    logic signed [PXW-1:0]    phase_x;
    logic signed [RXW-1:0]    ramp_x;
    logic signed [SXW-1:0]    start_x;
    logic [CNT_W:0]           cnt_inc;
    logic                     block_start;

    assign adv         = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !adv;
    assign o_out_valid = r_out_valid;
    assign o_saw_sample = r_saw;
    assign ld_start    = i_cfg_we && (t_cfg_index'(i_cfg_index) == CFG_START_PHASE);

    always_comb begin
        k = (r_block_log2 > K_MAX) ? K_MAX : r_block_log2;

        prod = r_freq * $signed({1'b0, r_inc_scale});
        inc  = $signed(prod[PROD_W-1:INC_SHIFT]);

        block_start = !r_control_mode || (r_cnt == '0);

        // step is increment times block length in control mode
        step_raw = STEP_W'(inc) <<< (r_control_mode ? k : KREG_W'(0));
        if (step_raw > STEP_LIM) begin
            step_sat = (PB+1)'(STEP_LIM);
        end else if (step_raw < -STEP_LIM) begin
            step_sat = (PB+1)'(-STEP_LIM);
        end else begin
            step_sat = step_raw[PB:0];
        end

        sum = (PB+2)'(r_phase) + (PB+2)'(step_sat);
        if (sum >= SUM_ONE) begin
            sum_wrap = sum - SUM_TWO;
        end else if (sum < -SUM_ONE) begin
            sum_wrap = sum + SUM_TWO;
        end else begin
            sum_wrap = sum;
        end

        target    = RW'(r_phase) <<< MAX_BLOCK_LOG2;
        diff      = (RW+1)'(target) - (RW+1)'(r_ramp);
        slope_use = (r_cnt == '0) ? (diff >>> k) : r_slope;
        ramp_sum  = (RW+2)'(r_ramp) + (RW+2)'(slope_use);

        phase_x = (PXW'(r_phase) >>> OUT_SHR) <<< OUT_SHL;
        ramp_x  = (RXW'(r_ramp) >>> RMP_SHR) <<< RMP_SHL;
        start_x = (SXW'($signed(i_cfg_data[START_W-1:0])) <<< SP_SHL) >>> SP_SHR;

        cnt_inc = (CNT_W+1)'(r_cnt) + (CNT_W+1)'(1);

        n_phase = block_start ? sum_wrap[PB-1:0] : r_phase;
        if (!r_control_mode) begin
            n_saw   = phase_x[OUT_W-1:0];
            n_ramp  = target;
            n_slope = '0;
            n_cnt   = '0;
        end else begin
            n_saw = ramp_x[OUT_W-1:0];
            if (ramp_sum > RAMP_HI) begin
                n_ramp = RAMP_HI[RW-1:0];
            end else if (ramp_sum < RAMP_LO) begin
                n_ramp = RAMP_LO[RW-1:0];
            end else begin
                n_ramp = ramp_sum[RW-1:0];
            end
            n_slope = slope_use;
            if (cnt_inc >= ((CNT_W+1)'(1) << k)) begin
                n_cnt = '0;
            end else begin
                n_cnt = cnt_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc_scale    <= '0;
            r_control_mode <= 1'b0;
            r_block_log2   <= BLOCK_LOG2_RESET;
            r_phase        <= '0;
            r_ramp         <= '0;
            r_slope        <= '0;
            r_cnt          <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // input register
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end

            // output register
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (ld_start) begin
                r_phase <= start_x[PB-1:0];
            end else if (adv) begin
                r_phase <= n_phase;
            end

            if (adv) begin
                r_ramp  <= n_ramp;
                r_slope <= n_slope;
                r_cnt   <= n_cnt;
            end

            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_INCREMENT_SCALE: r_inc_scale    <= i_cfg_data[SCALE_W-1:0];
                    CFG_CONTROL_MODE:    r_control_mode <= i_cfg_data[0];
                    CFG_BLOCK_SIZE_LOG2: r_block_log2   <= i_cfg_data[KREG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_freq <= i_frequency;
        end
        if (adv) begin
            r_saw <= n_saw;
        end
    end

endmodule

>>> sim/sawtooth_phase_oscillator_core_tb.sv
`timescale 1ns / 100ps

module sawtooth_phase_oscillator_core_tb;

    import spo_pkg::*;

    localparam int     STUCK_LIMIT = 2000;
    localparam longint PH_ONE      = 64'sd1 <<< (PHASE_BITS - 1);
    localparam longint PH_TWO      = 64'sd1 <<< PHASE_BITS;
    localparam longint RAMP_HI     = (PH_ONE <<< MAX_BLOCK_LOG2) - 1;
    localparam longint RAMP_LO     = -(PH_ONE <<< MAX_BLOCK_LOG2);

    localparam logic signed [FREQ_W-1:0] FREQ_MAX = {1'b0, {(FREQ_W-1){1'b1}}};
    localparam logic signed [FREQ_W-1:0] FREQ_MIN = {1'b1, {(FREQ_W-1){1'b0}}};
    localparam logic signed [FREQ_W-1:0] FREQ_A4  = FREQ_W'(440 * 256);
    localparam logic signed [FREQ_W-1:0] FREQ_ONE = FREQ_W'(1);
    localparam logic signed [FREQ_W-1:0] FREQ_NEG = '1;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data  = '0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    logic signed [FREQ_W-1:0]     i_frequency = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic signed [OUT_W-1:0]      o_saw_sample;

    sawtooth_phase_oscillator_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_frequency  (i_frequency),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_saw_sample (o_saw_sample)
    );

    always #6 i_clk = ~i_clk;

    // oscillator model state
    logic [SCALE_W-1:0] scale_reg;
    logic               ctrl_mode;
    logic [KREG_W-1:0]  blk_log2;
    longint             osc_phase;
    longint             ramp_level;
    longint             ramp_step;
    int                 blk_pos;

    logic signed [FREQ_W-1:0] pending_freqs[$];
    logic signed [OUT_W-1:0]  saw_expected[$];
    logic signed [OUT_W-1:0]  saw_want;

    int   err_count   = 0;
    int   idle_pct    = 0;
    int   in_gap      = 0;
    int   out_gap     = 0;
    int   stuck_count = 0;
    logic in_taken    = 1'b0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_count++;
    endtask

    function automatic longint clamp_step(input longint v);
        if (v > PH_TWO - 1) return PH_TWO - 1;
        if (v < -(PH_TWO - 1)) return -(PH_TWO - 1);
        return v;
    endfunction

    function automatic longint wrap_phase(input longint p);
        if (p >= PH_ONE) return p - PH_TWO;
        if (p < -PH_ONE) return p + PH_TWO;
        return p;
    endfunction

    function automatic logic signed [OUT_W-1:0] next_saw(input logic signed [FREQ_W-1:0] freq);
        longint inc;
        longint target;
        longint level;
        int     k;
        inc = (longint'(freq) * longint'({1'b0, scale_reg})) >>> INC_SHIFT;
        k   = (blk_log2 > MAX_BLOCK_LOG2) ? MAX_BLOCK_LOG2 : int'(blk_log2);
        if (!ctrl_mode) begin
            level      = osc_phase >>> (PHASE_BITS - OUT_W);
            ramp_level = osc_phase <<< MAX_BLOCK_LOG2;
            osc_phase  = wrap_phase(osc_phase + clamp_step(inc));
            ramp_step  = 0;
            blk_pos    = 0;
        end else begin
            if (blk_pos == 0) begin
                target    = osc_phase <<< MAX_BLOCK_LOG2;
                osc_phase = wrap_phase(osc_phase + clamp_step(inc <<< k));
                ramp_step = (target - ramp_level) >>> k;
            end
            level      = ramp_level >>> (PHASE_BITS + MAX_BLOCK_LOG2 - OUT_W);
            ramp_level = ramp_level + ramp_step;
            if (ramp_level > RAMP_HI) ramp_level = RAMP_HI;
            if (ramp_level < RAMP_LO) ramp_level = RAMP_LO;
            blk_pos++;
            if (blk_pos >= (1 << k)) blk_pos = 0;
        end
        return level[OUT_W-1:0];
    endfunction

    function automatic logic signed [FREQ_W-1:0] rand_freq();
        logic signed [FREQ_W-1:0] f;
        case ($urandom_range(0, 4))
            0: begin
                f = FREQ_W'($urandom_range(0, 20000 * 256));
                if ($urandom_range(0, 1)) f = -f;
            end
            1: begin
                case ($urandom_range(0, 4))
                    0: f = FREQ_MAX;
                    1: f = FREQ_MIN;
                    2: f = '0;
                    3: f = FREQ_ONE;
                    default: f = FREQ_NEG;
                endcase
            end
            2: begin
                f = FREQ_W'($urandom_range(0, 255));
                if ($urandom_range(0, 1)) f = -f;
            end
            default: f = FREQ_W'($urandom);
        endcase
        return f;
    endfunction

    function automatic logic [SCALE_W-1:0] rand_scale();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(20000000, 25000000);
            3: return $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_INCREMENT_SCALE: scale_reg = data[SCALE_W-1:0];
            CFG_CONTROL_MODE:    ctrl_mode = data[0];
            CFG_BLOCK_SIZE_LOG2: blk_log2  = data[KREG_W-1:0];
            CFG_START_PHASE:     osc_phase = longint'($signed(data[START_W-1:0]))
                                             <<< (PHASE_BITS - START_W);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // checked at the rising edge, where the driver never pops the queue
    task automatic wait_idle();
        while (pending_freqs.size() != 0 || i_in_valid || saw_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                in_gap     <= $urandom_range(0, 15);
                i_in_valid <= 1'b0;
            end else if (pending_freqs.size() != 0) begin
                i_in_valid  <= 1'b1;
                i_frequency <= pending_freqs.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap     <= out_gap - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            out_gap     <= $urandom_range(0, 15);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall)
                saw_expected.push_back(next_saw(i_frequency));
            if (o_out_valid && !i_out_stall) begin
                if (saw_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected saw sample %0d", o_saw_sample));
                end else begin
                    saw_want = saw_expected.pop_front();
                    if (o_saw_sample !== saw_want)
                        report_mismatch($sformatf("saw sample got %0d expected %0d",
                                                  o_saw_sample, saw_want));
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                stuck_count <= 0;
            else
                stuck_count <= stuck_count + 1;
            if (stuck_count >= STUCK_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        scale_reg  = '0;
        ctrl_mode  = 1'b0;
        blk_log2   = BLOCK_LOG2_RESET;
        osc_phase  = 0;
        ramp_level = 0;
        ramp_step  = 0;
        blk_pos    = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 20;

        // reset values: zero scale gives a flat output
        pending_freqs.push_back(FREQ_MAX);
        pending_freqs.push_back(FREQ_MIN);
        wait_idle();

        // audio mode, saturated step and wrap from both ends
        write_reg(CFG_INCREMENT_SCALE, '1);
        write_reg(CFG_START_PHASE, {{(CFG_DATA_W-START_W){1'b0}}, 1'b0, {(START_W-1){1'b1}}});
        pending_freqs.push_back(FREQ_MAX);
        pending_freqs.push_back(FREQ_MAX);
        pending_freqs.push_back(FREQ_MIN);
        pending_freqs.push_back(FREQ_MIN);
        pending_freqs.push_back('0);
        pending_freqs.push_back(FREQ_ONE);
        pending_freqs.push_back(FREQ_NEG);
        wait_idle();

        // control mode, one sample per block
        write_reg(CFG_START_PHASE, {{(CFG_DATA_W-START_W){1'b1}}, 1'b1, {(START_W-1){1'b0}}});
        write_reg(CFG_CONTROL_MODE, 1);
        write_reg(CFG_BLOCK_SIZE_LOG2, 0);
        pending_freqs.push_back(FREQ_MAX);
        pending_freqs.push_back(FREQ_MIN);
        pending_freqs.push_back(FREQ_ONE);
        pending_freqs.push_back(FREQ_NEG);
        wait_idle();

        // oversized block log2 acts as the maximum
        write_reg(CFG_INCREMENT_SCALE, 22906492);
        write_reg(CFG_BLOCK_SIZE_LOG2, 7);
        repeat (6) pending_freqs.push_back(FREQ_A4);
        wait_idle();

        // start phase reload and block size change mid block
        write_reg(CFG_START_PHASE, 32'h0040_0000);
        write_reg(CFG_BLOCK_SIZE_LOG2, 2);
        repeat (6) pending_freqs.push_back(-FREQ_A4);
        wait_idle();

        for (int p = 0; p < 11; p++) begin
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 30;
            endcase
            if (p == 10) idle_pct = 0;
            if ($urandom_range(0, 1)) write_reg(CFG_INCREMENT_SCALE, rand_scale());
            if ($urandom_range(0, 1)) write_reg(CFG_CONTROL_MODE, $urandom);
            if ($urandom_range(0, 1)) write_reg(CFG_BLOCK_SIZE_LOG2, $urandom);
            if ($urandom_range(0, 3) == 0) write_reg(CFG_START_PHASE, $urandom);
            repeat (50) pending_freqs.push_back(rand_freq());
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
